// File: rtl/core/npm_pkg.sv
// package for the non-overlapping pattern matcher
// holds item kind codes, the cell control struct and the result struct
// no dependencies
`timescale 1ns / 1ps

package npm_pkg;

  // request kind codes
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_SEQ     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned SlotBits  = 4;
  localparam int unsigned LenBits   = 5;
  localparam int unsigned CountBits = 16;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                shift_en;
    logic                load_en;
    logic [SlotBits-1:0] load_slot;
  } cell_ctrl_t;

  // one result item
  typedef struct packed {
    logic                 match_found;
    logic [CountBits-1:0] match_start;
    logic [CountBits-1:0] match_count;
  } result_t;

endpackage

// File: rtl/core/npm_req_if.sv
// request channel of the pattern matcher: valid, ready and one input item
// depends on npm_pkg
`timescale 1ns / 1ps

interface npm_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [npm_pkg::SlotBits-1:0]        pattern_index;
  logic signed [npm_pkg::WordBits-1:0] value;

  modport source (output valid, kind, pattern_index, value, input ready);
  modport sink   (input valid, kind, pattern_index, value, output ready);
endinterface

// File: rtl/core/npm_rsp_if.sv
// result channel of the pattern matcher: valid, ready and one result item
// depends on npm_pkg
`timescale 1ns / 1ps

interface npm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          match_found;
  logic [npm_pkg::CountBits-1:0] match_start;
  logic [npm_pkg::CountBits-1:0] match_count;

  modport source (output valid, match_found, match_start, match_count, input ready);
  modport sink   (input valid, match_found, match_start, match_count, output ready);
endinterface

// File: rtl/core/nonoverlapping_pattern_matcher.sv
// top level of the non-overlapping pattern matcher: cell chain, control, output skid
// depends on npm_pkg, npm_req_if, npm_rsp_if, npm_cell, npm_align
//
//   channel   dir   handshake      payload
//   req_i     in    valid/ready    kind, pattern_index, value
//   rsp_o     out   valid/ready    match_found, match_start, match_count
//   cfg       in    cfg_we_i       cfg_wdata_i (pattern_length)
//
// one request per cycle while req_i.ready is high; its result is registered
// the full-window compare is one equality per cell, all cells in parallel
// an output register plus a skid entry absorb one result while the output stalls;
// req_i.ready drops only while the skid entry is occupied
// reset clears counts and flags and sets the length to one; pattern slots are undefined
// until loaded
`timescale 1ns / 1ps

module nonoverlapping_pattern_matcher #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [npm_pkg::LenBits-1:0] cfg_wdata_i,
  npm_req_if.sink                     req_i,
  npm_rsp_if.source                   rsp_o
);

  localparam int unsigned LB = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CW = (LB > npm_pkg::LenBits) ? LB : npm_pkg::LenBits;
  localparam int unsigned SB = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned SW = (POSITION_BITS > npm_pkg::CountBits) ?
                               POSITION_BITS : npm_pkg::CountBits;
  localparam int unsigned WB = npm_pkg::WordBits;

  // configuration register
  logic [npm_pkg::LenBits-1:0] len_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= npm_pkg::LenBits'(1);
    end else if (cfg_we_i) begin
      len_cfg_q <= cfg_wdata_i;
    end
  end

  // length in use, clamped to 1..MAX_PATTERN
  logic [CW-1:0] len_ext;
  logic [LB-1:0] used_len;

  always_comb begin
    len_ext = CW'(len_cfg_q);
    if (len_ext == '0) begin
      used_len = LB'(1);
    end else if (len_ext > CW'(MAX_PATTERN)) begin
      used_len = LB'(MAX_PATTERN);
    end else begin
      used_len = LB'(len_ext);
    end
  end

  // request decode
  logic                req_acc;
  logic                is_seq;
  logic                is_load;
  logic                is_restart;
  npm_pkg::cell_ctrl_t cell_ctrl;

  assign req_acc    = req_i.valid && req_i.ready;
  assign is_seq     = req_acc && (req_i.kind == npm_pkg::KIND_SEQ);
  assign is_load    = req_acc && (req_i.kind == npm_pkg::KIND_LOAD);
  assign is_restart = req_acc && (req_i.kind == npm_pkg::KIND_RESTART);

  assign cell_ctrl.shift_en  = is_seq;
  assign cell_ctrl.load_en   = is_load;
  assign cell_ctrl.load_slot = req_i.pattern_index;

  // cell chain
  logic [MAX_PATTERN-1:0][WB-1:0] window;
  logic [MAX_PATTERN-1:0][WB-1:0] pattern;
  logic [MAX_PATTERN-1:0][WB-1:0] align;
  logic [MAX_PATTERN-1:0]         eq;
  logic [MAX_PATTERN-1:0]         used;

  for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
    logic [WB-1:0] shift_in;

    if (c == 0) begin : g_head
      assign shift_in = req_i.value;
    end else begin : g_link
      assign shift_in = window[c-1];
    end

    npm_cell #(
      .SLOT(c)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .shift_i    (shift_in),
      .load_word_i(req_i.value),
      .align_i    (align[c]),
      .window_o   (window[c]),
      .pattern_o  (pattern[c]),
      .eq_o       (eq[c])
    );

    assign used[c] = (LB'(c) < used_len);
  end

  logic [SB-1:0] align_shift;
  assign align_shift = SB'(LB'(MAX_PATTERN) - used_len);

  npm_align #(
    .MAX_PATTERN(MAX_PATTERN),
    .SHIFT_BITS (SB)
  ) u_align (
    .pattern_i(pattern),
    .shift_i  (align_shift),
    .align_o  (align)
  );

  // stream state
  logic [LB-1:0]                 fresh_q, fresh_d, fresh_inc;
  logic [POSITION_BITS-1:0]      position_q, position_d;
  logic [npm_pkg::CountBits-1:0] found_count_q, found_count_d;
  logic                          found;
  logic [SW-1:0]                 here_x, lm1_x, start_x;
  npm_pkg::result_t              result;

  // match decision and counter updates
  always_comb begin
    fresh_inc = (fresh_q < LB'(MAX_PATTERN)) ? fresh_q + LB'(1) : fresh_q;
    found     = is_seq && (fresh_inc >= used_len) && (&(eq | ~used));

    fresh_d       = fresh_q;
    position_d    = position_q;
    found_count_d = found_count_q;
    if (is_restart) begin
      fresh_d       = '0;
      position_d    = '0;
      found_count_d = '0;
    end else if (is_seq) begin
      fresh_d = found ? '0 : fresh_inc;
      if (position_q != '1) begin
        position_d = position_q + POSITION_BITS'(1);
      end
      if (found && (found_count_q != '1)) begin
        found_count_d = found_count_q + npm_pkg::CountBits'(1);
      end
    end

    here_x  = SW'(position_q);
    lm1_x   = SW'(used_len - LB'(1));
    start_x = (here_x >= lm1_x) ? here_x - lm1_x : '0;

    result.match_found = found;
    result.match_start = found ? start_x[npm_pkg::CountBits-1:0] : '0;
    result.match_count = found_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q       <= '0;
      position_q    <= '0;
      found_count_q <= '0;
    end else begin
      fresh_q       <= fresh_d;
      position_q    <= position_d;
      found_count_q <= found_count_d;
    end
  end

  // output register and skid entry
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  npm_pkg::result_t out_q, out_d;
  npm_pkg::result_t skid_q, skid_d;
  logic             take;

  assign take        = out_valid_q && rsp_o.ready;
  assign req_i.ready = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (req_acc) begin
      if (!out_valid_q || take) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.match_found = out_q.match_found;
  assign rsp_o.match_start = out_q.match_start;
  assign rsp_o.match_count = out_q.match_count;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while output register empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !take) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid entry lost while output stalled");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_restart |=> (position_q == '0 && fresh_q == '0 && found_count_q == '0))
    else $error("restart did not clear stream state");

  a_match_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found && (found_count_q != '1)) |=>
      (found_count_q == $past(found_count_q) + npm_pkg::CountBits'(1) && fresh_q == '0))
    else $error("match did not advance count or clear fresh words");

endmodule

// File: rtl/core/npm_cell.sv
// one cell of the matcher chain: a window word, a pattern slot and a comparator
// depends on npm_pkg
`timescale 1ns / 1ps

module npm_cell #(
  parameter int unsigned SLOT = 0
) (
  input  logic                         clk_i,
  input  npm_pkg::cell_ctrl_t          ctrl_i,
  input  logic [npm_pkg::WordBits-1:0] shift_i,
  input  logic [npm_pkg::WordBits-1:0] load_word_i,
  input  logic [npm_pkg::WordBits-1:0] align_i,
  output logic [npm_pkg::WordBits-1:0] window_o,
  output logic [npm_pkg::WordBits-1:0] pattern_o,
  output logic                         eq_o
);

  logic [npm_pkg::WordBits-1:0] window_q;
  logic [npm_pkg::WordBits-1:0] pattern_q;

  // window word moves one cell along the chain on each sequence word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      window_q <= shift_i;
    end
  end

  // pattern slot owned by this cell
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en && (32'(ctrl_i.load_slot) == SLOT)) begin
      pattern_q <= load_word_i;
    end
  end

  // compare the word arriving here against the aligned pattern word
  assign eq_o      = (shift_i == align_i);
  assign window_o  = window_q;
  assign pattern_o = pattern_q;

endmodule

// File: rtl/core/npm_align.sv
// aligns the pattern slots to the window cells for the length in use
// cell c gets slot (len-1-c); log-depth shifter over the reversed slots
// depends on npm_pkg
`timescale 1ns / 1ps

module npm_align #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned SHIFT_BITS  = 4
) (
  input  logic [MAX_PATTERN-1:0][npm_pkg::WordBits-1:0] pattern_i,
  input  logic [SHIFT_BITS-1:0]                         shift_i,
  output logic [MAX_PATTERN-1:0][npm_pkg::WordBits-1:0] align_o
);

  logic [SHIFT_BITS:0][MAX_PATTERN-1:0][npm_pkg::WordBits-1:0] stage;

  // reverse the slots, then shift down by MAX_PATTERN - len
  always_comb begin
    for (int c = 0; c < MAX_PATTERN; c++) begin
      stage[0][c] = pattern_i[MAX_PATTERN-1-c];
    end
    for (int b = 0; b < SHIFT_BITS; b++) begin
      for (int c = 0; c < MAX_PATTERN; c++) begin
        if (!shift_i[b]) begin
          stage[b+1][c] = stage[b][c];
        end else if (c + (1 << b) < MAX_PATTERN) begin
          stage[b+1][c] = stage[b][c + (1 << b)];
        end else begin
          stage[b+1][c] = '0;
        end
      end
    end
  end

  assign align_o = stage[SHIFT_BITS];

endmodule

// File: tb/npm_match_checker.sv
// result checker for the non-overlapping pattern matcher
// watches the config port and both channels, predicts each result and compares it
// depends on npm_pkg, npm_req_if, npm_rsp_if
`timescale 1ns / 1ps

module npm_match_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [npm_pkg::LenBits-1:0] cfg_wdata_i,
  npm_req_if                          req_i,
  npm_rsp_if                          rsp_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 matches_o
);

  localparam int unsigned MaxPattern = 16;
  localparam logic [15:0] PosMax     = 16'hFFFF;

  // predictor state
  logic [npm_pkg::WordBits-1:0]  pattern_words [MaxPattern];
  logic [npm_pkg::WordBits-1:0]  recent_words  [MaxPattern];
  int unsigned                   fresh_words;
  logic [15:0]                   stream_pos;
  logic [npm_pkg::CountBits-1:0] found_count;
  logic [npm_pkg::LenBits-1:0]   length_reg;

  npm_pkg::result_t awaited_results [$];
  int unsigned      fail_count;
  int unsigned      match_total;

  task automatic clear_stream();
    for (int k = 0; k < MaxPattern; k++) recent_words[k] = '0;
    fresh_words = 0;
    stream_pos  = '0;
    found_count = '0;
  endtask

  // one request in, one predicted result out, state updated
  task automatic predict_match(input logic [1:0] kind,
                               input logic [npm_pkg::SlotBits-1:0] slot,
                               input logic [npm_pkg::WordBits-1:0] word,
                               output npm_pkg::result_t res);
    int unsigned len;
    logic [15:0] here;
    logic        same;
    res = '0;
    case (kind)
      npm_pkg::KIND_LOAD: begin
        pattern_words[slot] = word;
      end
      npm_pkg::KIND_RESTART: begin
        clear_stream();
      end
      npm_pkg::KIND_SEQ: begin
        // zero acts as one, anything past the store depth as the full store
        if (length_reg == 0) len = 1;
        else if (length_reg > MaxPattern) len = MaxPattern;
        else len = length_reg;
        here = stream_pos;
        for (int k = MaxPattern - 1; k > 0; k--) recent_words[k] = recent_words[k-1];
        recent_words[0] = word;
        if (fresh_words < MaxPattern) fresh_words++;
        if (stream_pos != PosMax) stream_pos++;
        // only words after the last match may form the next window
        if (fresh_words >= len) begin
          same = 1'b1;
          for (int j = 0; j < len; j++) begin
            if (pattern_words[j] != recent_words[len-1-j]) same = 1'b0;
          end
          if (same) begin
            res.match_found = 1'b1;
            res.match_start = (here >= len - 1) ? 16'(here - (len - 1)) : '0;
            fresh_words = 0;
            if (found_count != '1) found_count++;
          end
        end
      end
      default: begin
        // reserved kind leaves all state alone
      end
    endcase
    res.match_count = found_count;
  endtask

  // compare accepted results, then predict accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    npm_pkg::result_t oldest;
    npm_pkg::result_t next_res;
    if (!rst_ni) begin
      for (int k = 0; k < MaxPattern; k++) pattern_words[k] = '0;
      clear_stream();
      length_reg = 5'd1;
      awaited_results.delete();
      fail_count  = 0;
      match_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      matches_o    <= 0;
    end else begin
      // a result taken at this edge belongs to an earlier request
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (rsp_i.match_found !== oldest.match_found) begin
            $error("match_found: expected %0d, got %0d", oldest.match_found,
                   rsp_i.match_found);
            fail_count++;
          end
          if (rsp_i.match_start !== oldest.match_start) begin
            $error("match_start: expected %0d, got %0d", oldest.match_start,
                   rsp_i.match_start);
            fail_count++;
          end
          if (rsp_i.match_count !== oldest.match_count) begin
            $error("match_count: expected %0d, got %0d", oldest.match_count,
                   rsp_i.match_count);
            fail_count++;
          end
          if (oldest.match_found) match_total++;
        end
      end
      if (cfg_we_i) length_reg = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        predict_match(req_i.kind, req_i.pattern_index, req_i.value, next_res);
        awaited_results.push_back(next_res);
      end
      fail_count_o <= fail_count;
      pending_o    <= awaited_results.size();
      matches_o    <= match_total;
    end
  end

endmodule

// File: tb/tb.sv
// top of the pattern matcher testbench: clock, reset, request and stall generation
// drives directed and random request streams, the checker judges every result
// depends on npm_pkg, npm_req_if, npm_rsp_if, nonoverlapping_pattern_matcher, npm_match_checker
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0]  KIND_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 50000;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned STRETCH_WORDS = 120;
  localparam int unsigned NUM_PHASES    = 10;
  localparam logic [npm_pkg::WordBits-1:0] EDGE_WORDS [4] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
  };
  localparam logic [npm_pkg::LenBits-1:0] PHASE_LENGTHS [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd4, 5'd3, 5'd7, 5'd12, 5'd5
  };

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [npm_pkg::LenBits-1:0] cfg_wdata;
  logic                        gaps_on = 1'b1;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned match_tally;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned eff_len = 1;
  logic [npm_pkg::WordBits-1:0] pat_words [16];

  npm_req_if req_if ();
  npm_rsp_if rsp_if ();

  nonoverlapping_pattern_matcher dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  npm_match_checker checker_u (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .matches_o   (match_tally)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= !gaps_on || ($urandom_range(99) >= 28);
    end
  end

  // one request, held until accepted; valid stays up for a following request
  task automatic push_req(input logic [1:0] kind, input logic [npm_pkg::SlotBits-1:0] slot,
                          input logic [npm_pkg::WordBits-1:0] word);
    while (gaps_on && $urandom_range(99) < 28) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.kind          <= kind;
    req_if.pattern_index <= slot;
    req_if.value         <= word;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_word(input logic [npm_pkg::WordBits-1:0] word);
    push_req(npm_pkg::KIND_SEQ, npm_pkg::SlotBits'($urandom_range(15)), word);
  endtask

  task automatic load_slot(input int unsigned slot, input logic [npm_pkg::WordBits-1:0] word);
    push_req(npm_pkg::KIND_LOAD, slot[npm_pkg::SlotBits-1:0], word);
    pat_words[slot] = word;
  endtask

  // drain everything outstanding, then write the length register
  task automatic set_length(input logic [npm_pkg::LenBits-1:0] len);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (len == 0) eff_len = 1;
    else if (len > 16) eff_len = 16;
    else eff_len = len;
  endtask

  // narrow words come from a two-letter alphabet so windows overlap often
  function automatic logic [npm_pkg::WordBits-1:0] noise_word(input logic narrow);
    case ($urandom_range(3))
      0:       return EDGE_WORDS[2'($urandom_range(3))];
      1:       return pat_words[4'($urandom_range(15))];
      default: return narrow ? npm_pkg::WordBits'($urandom_range(1))
                             : npm_pkg::WordBits'($urandom());
    endcase
  endfunction

  // one random phase under a fixed length setting
  task automatic run_phase(input logic [npm_pkg::LenBits-1:0] len, input logic narrow);
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    logic [npm_pkg::WordBits-1:0] word;
    set_length(len);
    for (int i = 0; i < 16; i++) begin
      load_slot(i, narrow ? npm_pkg::WordBits'($urandom_range(1))
                          : npm_pkg::WordBits'($urandom()));
    end
    target = sent + PHASE_ITEMS;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // whole pattern occurrence
        for (int k = 0; k < eff_len; k++) send_word(pat_words[k]);
      end else if (pick < 70) begin
        // prefix with its last word corrupted
        cut = $urandom_range(eff_len, 1);
        for (int k = 0; k < cut; k++) begin
          word = pat_words[k];
          if (k == cut - 1) word[5'($urandom_range(31))] ^= 1'b1;
          send_word(word);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 1)) send_word(noise_word(narrow));
      end else if (pick < 90) begin
        push_req(npm_pkg::KIND_RESTART, npm_pkg::SlotBits'($urandom_range(15)), $urandom());
      end else if (pick < 94) begin
        load_slot($urandom_range(15),
                  narrow ? npm_pkg::WordBits'($urandom_range(1))
                         : npm_pkg::WordBits'($urandom()));
      end else if (pick < 97) begin
        push_req(KIND_RESERVED, npm_pkg::SlotBits'($urandom_range(15)), $urandom());
      end else begin
        send_word($urandom());
      end
    end
  endtask

  initial begin
    logic [npm_pkg::WordBits-1:0] run_word;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_if.valid         <= 1'b0;
    req_if.kind          <= npm_pkg::KIND_LOAD;
    req_if.pattern_index <= '0;
    req_if.value         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme pattern words, length one from reset, reserved kind, restart
    for (int i = 0; i < 16; i++) begin
      load_slot(i, (i < 4) ? EDGE_WORDS[2'(i)] : 32'h0101_0101 * i);
    end
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    push_req(KIND_RESERVED, 4'hF, 32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    push_req(npm_pkg::KIND_RESTART, 4'h0, 32'h0000_0000);
    send_word(32'h8000_0000);

    // random phases over in-range and out-of-range lengths
    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(PHASE_LENGTHS[p], p[0]);
    end

    // long unbroken stream of back to back matches with no idling on either side
    set_length(5'd1);
    push_req(npm_pkg::KIND_RESTART, 4'h0, 32'h0);
    run_word = $urandom();
    load_slot(0, run_word);
    gaps_on = 1'b0;
    repeat (STRETCH_WORDS) send_word(run_word);
    // matches right after a mismatch and around a reserved kind
    set_length(5'd3);
    for (int k = 0; k < 3; k++) send_word(pat_words[k]);
    send_word(~pat_words[0]);
    push_req(KIND_RESERVED, 4'h5, $urandom());
    gaps_on = 1'b1;
    for (int k = 0; k < 3; k++) send_word(pat_words[k]);
    push_req(npm_pkg::KIND_RESTART, 4'hA, $urandom());

    // drain
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("run covered %0d requests and %0d matches over lengths 0 to 31,",
             sent, match_tally);
    $display("with restarts, reserved kinds, stalls and an unbroken back to back stretch");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
